/* hdl/rbec_pkg.sv */
// rbec_pkg: shared widths, constants, codes and the per-item control type of the box
// expansion and clamp pipeline. No dependencies.
`default_nettype none

package rbec_pkg;

  // Fixed-point format of the side ratios
  localparam int RATIO_W         = 16;
  localparam int RATIO_FRAC_BITS = 12;
  localparam int RATIO_HALF      = 1 << (RATIO_FRAC_BITS - 1);

  // Image and crop dimensions
  localparam int MAX_DIM = 8192;
  localparam int DIM_W   = 14;

  // Box coordinates and datapath widths
  localparam int COORD_W  = 32;
  localparam int ANCHOR_W = COORD_W + 1;             // x + w, centre
  localparam int COEF_W   = RATIO_W + 1;             // ratio + 0.5
  localparam int PROD_W   = ANCHOR_W + COEF_W;       // signed length * coef
  localparam int SUM_W    = PROD_W + 1;              // scaled anchor +/- product

  localparam int NUM_EDGES = 4;

  // Stream payload widths
  localparam int IN_DATA_W  = 160;
  localparam int OUT_DATA_W = 64;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_RATIO    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_RATIO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_RATIO     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_RATIO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE_ENABLE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_SELECT   = 3'd5;

  // Square base length selection
  localparam logic [1:0] BASE_MAX = 2'd0;
  localparam logic [1:0] BASE_MIN = 2'd1;

  // Result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_BAD_BOX = 2'd1;
  localparam logic [1:0] STATUS_EMPTY   = 2'd2;

  // Edge order in the datapath arrays
  localparam int EDGE_LEFT   = 0;
  localparam int EDGE_RIGHT  = 1;
  localparam int EDGE_TOP    = 2;
  localparam int EDGE_BOTTOM = 3;

  // Per-item control carried alongside the datapath
  typedef struct packed {
    logic             bad_box;
    logic [DIM_W-1:0] lim_w;
    logic [DIM_W-1:0] lim_h;
  } ctl_t;

endpackage

`default_nettype wire

/* hdl/roi_box_expand_clamp.sv */
// roi_box_expand_clamp: five-stage pipeline that expands a detection box by
// four side ratios (plain or square mode) and clamps it to the image.
// Throughput: one request per cycle while m_axis_tready is held high; each
// stage holds one item, and a stage advances whenever it is empty or the
// stage after it advances.
// Reset (rst, synchronous): clears all stage valid bits and the ratio/mode
// registers to 0; configuration writes are taken in every cycle outside reset.
// Depends on rbec_pkg.
`default_nettype none

module roi_box_expand_clamp
  import rbec_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,

  // Configuration write channel
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [RATIO_W-1:0]    cfg_data,

  // Box requests
  input  wire logic                  s_axis_tvalid,
  output      logic                  s_axis_tready,
  // tdata, low bit up: box_x[31:0], box_y[63:32], box_w[95:64], box_h[127:96],
  // image_width[141:128], image_height[155:142], zero pad[159:156]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,

  // Crop results
  output      logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // tdata, low bit up: crop_left[13:0], crop_top[27:14], crop_width[41:28],
  // crop_height[55:42], status[57:56], zero pad[63:58]
  output      logic [OUT_DATA_W-1:0] m_axis_tdata
);

  // ------------------------------------------------------------------
  // Configuration registers. The user must write them only while the pipe is idle; the block does not enforce it.
  // ------------------------------------------------------------------
  logic signed [RATIO_W-1:0] ratio [NUM_EDGES];
  logic                      square_enable;
  logic [1:0]                base_select;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_EDGES; i++) begin
        ratio[i] <= '0;
      end
      square_enable <= 1'b0;
      base_select   <= BASE_MAX;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LEFT_RATIO:    ratio[EDGE_LEFT]   <= cfg_data;
        CFG_RIGHT_RATIO:   ratio[EDGE_RIGHT]  <= cfg_data;
        CFG_TOP_RATIO:     ratio[EDGE_TOP]    <= cfg_data;
        CFG_BOTTOM_RATIO:  ratio[EDGE_BOTTOM] <= cfg_data;
        CFG_SQUARE_ENABLE: square_enable      <= cfg_data[0];
        CFG_BASE_SELECT:   base_select        <= cfg_data[1:0];
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Flow control: each stage moves when empty or when the next one moves.
  // ------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic en1, en2, en3, en4, en5;

  assign en5 = !s5_valid || m_axis_tready;
  assign en4 = !s4_valid || en5;
  assign en3 = !s3_valid || en4;
  assign en2 = !s2_valid || en3;
  assign en1 = !s1_valid || en2;

  assign s_axis_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else begin
      if (en1) s1_valid <= s_axis_tvalid;
      if (en2) s2_valid <= s1_valid;
      if (en3) s3_valid <= s2_valid;
      if (en4) s4_valid <= s3_valid;
      if (en5) s5_valid <= s4_valid;
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: unpack the request, pick anchors, lengths and coefficients.
  // Each edge becomes anchor * 2^F +/- length * coef.
  // ------------------------------------------------------------------
  logic signed [COORD_W-1:0] in_x, in_y, in_w, in_h;
  logic [DIM_W-1:0]          in_iw, in_ih;

  assign in_x  = s_axis_tdata[31:0];
  assign in_y  = s_axis_tdata[63:32];
  assign in_w  = s_axis_tdata[95:64];
  assign in_h  = s_axis_tdata[127:96];
  assign in_iw = s_axis_tdata[141:128];
  assign in_ih = s_axis_tdata[155:142];

  logic signed [ANCHOR_W-1:0] anchor_next [NUM_EDGES];
  logic signed [COEF_W-1:0]   coef_next   [NUM_EDGES];
  logic [COORD_W-1:0]         len_x_next, len_y_next;
  ctl_t                       ctl1_next;

  logic signed [ANCHOR_W-1:0] x_ext, y_ext, cx, cy;
  logic [COORD_W:0]           wh_sum;
  logic [COORD_W-1:0]         base;

  always_comb begin
    x_ext  = {in_x[COORD_W-1], in_x};
    y_ext  = {in_y[COORD_W-1], in_y};
    // w and h are positive whenever the result is used: halve by shift
    cx     = x_ext + $signed({2'b00, in_w[COORD_W-1:1]});
    cy     = y_ext + $signed({2'b00, in_h[COORD_W-1:1]});
    wh_sum = {1'b0, in_w} + {1'b0, in_h};

    case (base_select)
      BASE_MAX: base = (in_w > in_h) ? in_w : in_h;
      BASE_MIN: base = (in_w < in_h) ? in_w : in_h;
      default:  base = wh_sum[COORD_W:1];  // mean; unused code acts as mean
    endcase

    if (square_enable) begin
      for (int i = 0; i < NUM_EDGES; i++) begin
        coef_next[i] = $signed({ratio[i][RATIO_W-1], ratio[i]})
                       + $signed(COEF_W'(RATIO_HALF));
      end
      anchor_next[EDGE_LEFT]   = cx;
      anchor_next[EDGE_RIGHT]  = cx;
      anchor_next[EDGE_TOP]    = cy;
      anchor_next[EDGE_BOTTOM] = cy;
      len_x_next = base;
      len_y_next = base;
    end else begin
      for (int i = 0; i < NUM_EDGES; i++) begin
        coef_next[i] = $signed({ratio[i][RATIO_W-1], ratio[i]});
      end
      anchor_next[EDGE_LEFT]   = x_ext;
      anchor_next[EDGE_RIGHT]  = x_ext + {in_w[COORD_W-1], in_w};
      anchor_next[EDGE_TOP]    = y_ext;
      anchor_next[EDGE_BOTTOM] = y_ext + {in_h[COORD_W-1], in_h};
      len_x_next = in_w;
      len_y_next = in_h;
    end

    ctl1_next.bad_box = (in_w <= 0) || (in_h <= 0);
    ctl1_next.lim_w   = (in_iw > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : in_iw;
    ctl1_next.lim_h   = (in_ih > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : in_ih;
  end

  logic signed [ANCHOR_W-1:0] s1_anchor [NUM_EDGES];
  logic signed [COEF_W-1:0]   s1_coef   [NUM_EDGES];
  logic [COORD_W-1:0]         s1_len_x, s1_len_y;
  ctl_t                       s1_ctl;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_anchor <= anchor_next;
      s1_coef   <= coef_next;
      s1_len_x  <= len_x_next;
      s1_len_y  <= len_y_next;
      s1_ctl    <= ctl1_next;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: one 33x17 signed multiply per edge.
  // ------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod_next [NUM_EDGES];

  always_comb begin
    for (int i = 0; i < NUM_EDGES; i++) begin
      if (i < EDGE_TOP) begin
        prod_next[i] = $signed({1'b0, s1_len_x}) * s1_coef[i];
      end else begin
        prod_next[i] = $signed({1'b0, s1_len_y}) * s1_coef[i];
      end
    end
  end

  logic signed [PROD_W-1:0]   s2_prod   [NUM_EDGES];
  logic signed [ANCHOR_W-1:0] s2_anchor [NUM_EDGES];
  ctl_t                       s2_ctl;

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_prod   <= prod_next;
      s2_anchor <= s1_anchor;
      s2_ctl    <= s1_ctl;
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: scaled anchor minus (left, top) or plus (right, bottom) product.
  // ------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum_next [NUM_EDGES];
  logic signed [SUM_W-1:0] anchor_scaled;

  always_comb begin
    anchor_scaled = '0;
    for (int i = 0; i < NUM_EDGES; i++) begin
      anchor_scaled = SUM_W'(s2_anchor[i]) <<< RATIO_FRAC_BITS;
      if (i == EDGE_LEFT || i == EDGE_TOP) begin
        sum_next[i] = anchor_scaled - SUM_W'(s2_prod[i]);
      end else begin
        sum_next[i] = anchor_scaled + SUM_W'(s2_prod[i]);
      end
    end
  end

  logic signed [SUM_W-1:0] s3_sum [NUM_EDGES];
  ctl_t                    s3_ctl;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_sum <= sum_next;
      s3_ctl <= s2_ctl;
    end
  end

  // ------------------------------------------------------------------
  // Stage 4: unscale and clamp. Any negative sum truncates to at most zero
  // and clamps to zero, so only non-negative sums need the shift.
  // ------------------------------------------------------------------
  localparam int WHOLE_W = SUM_W - RATIO_FRAC_BITS;

  logic [DIM_W-1:0]   edge_next [NUM_EDGES];
  logic [WHOLE_W-1:0] whole;
  logic [DIM_W-1:0]   lim;

  always_comb begin
    whole = '0;
    lim   = '0;
    for (int i = 0; i < NUM_EDGES; i++) begin
      whole = s3_sum[i][SUM_W-1:RATIO_FRAC_BITS];
      lim   = (i < EDGE_TOP) ? s3_ctl.lim_w : s3_ctl.lim_h;
      if (s3_sum[i][SUM_W-1]) begin
        edge_next[i] = '0;
      end else if (whole > WHOLE_W'(lim)) begin
        edge_next[i] = lim;
      end else begin
        edge_next[i] = whole[DIM_W-1:0];
      end
    end
  end

  logic [DIM_W-1:0] s4_edge [NUM_EDGES];
  logic             s4_bad_box;

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_edge    <= edge_next;
      s4_bad_box <= s3_ctl.bad_box;
    end
  end

  // ------------------------------------------------------------------
  // Stage 5 (output register): emptiness check, status and sizes.
  // ------------------------------------------------------------------
  logic [DIM_W-1:0] left_next, top_next, width_next, height_next;
  logic [1:0]       status_next;

  always_comb begin
    left_next   = '0;
    top_next    = '0;
    width_next  = '0;
    height_next = '0;
    if (s4_bad_box) begin
      status_next = STATUS_BAD_BOX;
    end else if (s4_edge[EDGE_LEFT] >= s4_edge[EDGE_RIGHT] ||
                 s4_edge[EDGE_TOP] >= s4_edge[EDGE_BOTTOM]) begin
      status_next = STATUS_EMPTY;
    end else begin
      status_next = STATUS_OK;
      left_next   = s4_edge[EDGE_LEFT];
      top_next    = s4_edge[EDGE_TOP];
      width_next  = s4_edge[EDGE_RIGHT] - s4_edge[EDGE_LEFT];
      height_next = s4_edge[EDGE_BOTTOM] - s4_edge[EDGE_TOP];
    end
  end

  logic [DIM_W-1:0] crop_left, crop_top, crop_width, crop_height;
  logic [1:0]       status;

  always_ff @(posedge clk) begin
    if (en5) begin
      crop_left   <= left_next;
      crop_top    <= top_next;
      crop_width  <= width_next;
      crop_height <= height_next;
      status      <= status_next;
    end
  end

  assign m_axis_tvalid = s5_valid;
  assign m_axis_tdata  = {6'd0, status, crop_height, crop_width, crop_top, crop_left};

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  // Input stalls only when the whole pipe is backed up by the output.
  assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (s1_valid && s2_valid && s3_valid && s4_valid &&
                        s5_valid && !m_axis_tready))
    else $error("input stalled while the pipe has room");

  // A good crop is never empty.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && status == STATUS_OK) |-> (crop_width != '0 && crop_height != '0))
    else $error("ok status with empty crop");

  // A good crop stays inside the largest image.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && status == STATUS_OK) |->
      ((15'(crop_left) + 15'(crop_width)) <= 15'(MAX_DIM) &&
       (15'(crop_top) + 15'(crop_height)) <= 15'(MAX_DIM)))
    else $error("crop beyond image limit");

  // Failed results carry no rectangle.
  assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (status == STATUS_BAD_BOX || status == STATUS_EMPTY)) |->
      (crop_left == '0 && crop_top == '0 && crop_width == '0 && crop_height == '0))
    else $error("failed result with nonzero rectangle");

  // Reset empties the pipe.
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

`default_nettype wire

/* sim/roi_box_expand_clamp_tb.sv */
// roi_box_expand_clamp_tb: self-checking bench for the box expansion and clamp
// pipeline. It predicts every crop from the accepted box requests and the
// written ratio and mode registers. Depends on rbec_pkg and roi_box_expand_clamp.
`default_nettype none

module roi_box_expand_clamp_tb
  import rbec_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Box request as it travels on s_axis_tdata, first field in the low bits
  typedef struct packed {
    logic [3:0]                pad;
    logic [DIM_W-1:0]          img_h;
    logic [DIM_W-1:0]          img_w;
    logic signed [COORD_W-1:0] h;
    logic signed [COORD_W-1:0] w;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } box_t;

  // Crop result as it travels on m_axis_tdata
  typedef struct packed {
    logic [5:0]       pad;
    logic [1:0]       status;
    logic [DIM_W-1:0] height;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] top;
    logic [DIM_W-1:0] left;
  } crop_t;

  // Square base codes the package leaves unnamed
  localparam logic [1:0] BASE_MEAN  = 2'd2;
  localparam logic [1:0] BASE_SPARE = 2'd3;

  // First register index past the defined ones; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_BASE_SELECT + 3'd1;

  localparam int COORD_MIN = 32'sh8000_0000;
  localparam int COORD_MAX = 32'sh7FFF_FFFF;

  localparam int NUM_PHASES      = 15;
  localparam int BOXES_PER_PHASE = 72;
  localparam int DRAIN_CYCLES    = 10;

  // Tracks the register file and the crops still owed by the pipeline.
  class crop_scoreboard;
    logic [RATIO_W-1:0] side_ratio [NUM_EDGES];
    logic               square_on;
    logic [1:0]         base_sel;
    crop_t              crops_due [$];
    int                 errors;

    function new();
      foreach (side_ratio[i]) side_ratio[i] = '0;
      square_on = 1'b0;
      base_sel  = BASE_MAX;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [RATIO_W-1:0] val);
      case (idx)
        CFG_LEFT_RATIO:    side_ratio[EDGE_LEFT]   = val;
        CFG_RIGHT_RATIO:   side_ratio[EDGE_RIGHT]  = val;
        CFG_TOP_RATIO:     side_ratio[EDGE_TOP]    = val;
        CFG_BOTTOM_RATIO:  side_ratio[EDGE_BOTTOM] = val;
        CFG_SQUARE_ENABLE: square_on = val[0];
        CFG_BASE_SELECT:   base_sel  = val[1:0];
        default: ;
      endcase
    endfunction

    function longint clamp_edge(longint v, longint hi);
      if (v < 0) return 0;
      return (v > hi) ? hi : v;
    endfunction

    // Expand one box by the current ratios and clip it to the image
    function crop_t expand_box(box_t b);
      longint one, x, y, w, h, iw, ih, base, cx, cy;
      longint coef [NUM_EDGES];
      longint pos  [NUM_EDGES];
      crop_t  c;
      one = longint'(1) << RATIO_FRAC_BITS;
      x   = longint'(b.x);
      y   = longint'(b.y);
      w   = longint'(b.w);
      h   = longint'(b.h);
      iw  = b.img_w;
      ih  = b.img_h;
      if (iw > MAX_DIM) iw = MAX_DIM;
      if (ih > MAX_DIM) ih = MAX_DIM;
      c = '0;
      if (w <= 0 || h <= 0) begin
        c.status = STATUS_BAD_BOX;
        return c;
      end
      foreach (coef[i]) coef[i] = longint'($signed(side_ratio[i]));
      if (square_on) begin
        cx = x + w / 2;
        cy = y + h / 2;
        case (base_sel)
          BASE_MAX: base = (w > h) ? w : h;
          BASE_MIN: base = (w < h) ? w : h;
          default:  base = (w + h) / 2;
        endcase
        pos[EDGE_LEFT]   = (cx * one - base * (coef[EDGE_LEFT] + RATIO_HALF)) / one;
        pos[EDGE_RIGHT]  = (cx * one + base * (coef[EDGE_RIGHT] + RATIO_HALF)) / one;
        pos[EDGE_TOP]    = (cy * one - base * (coef[EDGE_TOP] + RATIO_HALF)) / one;
        pos[EDGE_BOTTOM] = (cy * one + base * (coef[EDGE_BOTTOM] + RATIO_HALF)) / one;
      end else begin
        pos[EDGE_LEFT]   = (x * one - w * coef[EDGE_LEFT]) / one;
        pos[EDGE_RIGHT]  = ((x + w) * one + w * coef[EDGE_RIGHT]) / one;
        pos[EDGE_TOP]    = (y * one - h * coef[EDGE_TOP]) / one;
        pos[EDGE_BOTTOM] = ((y + h) * one + h * coef[EDGE_BOTTOM]) / one;
      end
      pos[EDGE_LEFT]   = clamp_edge(pos[EDGE_LEFT], iw);
      pos[EDGE_RIGHT]  = clamp_edge(pos[EDGE_RIGHT], iw);
      pos[EDGE_TOP]    = clamp_edge(pos[EDGE_TOP], ih);
      pos[EDGE_BOTTOM] = clamp_edge(pos[EDGE_BOTTOM], ih);
      if (pos[EDGE_LEFT] >= pos[EDGE_RIGHT] || pos[EDGE_TOP] >= pos[EDGE_BOTTOM]) begin
        c.status = STATUS_EMPTY;
        return c;
      end
      c.left   = DIM_W'(pos[EDGE_LEFT]);
      c.top    = DIM_W'(pos[EDGE_TOP]);
      c.width  = DIM_W'(pos[EDGE_RIGHT] - pos[EDGE_LEFT]);
      c.height = DIM_W'(pos[EDGE_BOTTOM] - pos[EDGE_TOP]);
      c.status = STATUS_OK;
      return c;
    endfunction

    function void note_box(box_t b);
      crops_due.insert(crops_due.size(), expand_box(b));
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_crop(crop_t got);
      crop_t want;
      if (crops_due.size() == 0) begin
        errors++;
        $display("%0t: crop with no request pending, expected none, got %h", $time, got);
        return;
      end
      want = crops_due.pop_front();
      check_field("crop_left",   want.left,   got.left);
      check_field("crop_top",    want.top,    got.top);
      check_field("crop_width",  want.width,  got.width);
      check_field("crop_height", want.height, got.height);
      check_field("status",      want.status, got.status);
    endfunction

    function int pending();
      return crops_due.size();
    endfunction
  endclass

  // Clock, reset and block ports; every input starts at a known value
  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [RATIO_W-1:0]    cfg_data = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Idle percentages of the request side and the result side
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;

  crop_scoreboard sb = new();

  roi_box_expand_clamp u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Stall the result side at the current rate; zero means never stall
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Observe every handshake at the edge it completes on. Signals here were
  // driven by nonblocking assignments at the previous edge, so they are stable.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready) sb.note_box(box_t'(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) sb.check_crop(crop_t'(m_axis_tdata));
    end
  end

  function automatic box_t box_of(int x, int y, int w, int h, int iw, int ih);
    box_t b;
    b       = '0;
    b.x     = x;
    b.y     = y;
    b.w     = w;
    b.h     = h;
    b.img_w = DIM_W'(iw);
    b.img_h = DIM_W'(ih);
    return b;
  endfunction

  // Mostly moderate ratios so that crops survive, with the extremes mixed in
  function automatic logic [RATIO_W-1:0] pick_ratio();
    int v;
    case ($urandom_range(9))
      0:       v = -32768;
      1:       v = 32767;
      2:       v = int'($urandom_range(65535)) - 32768;
      default: v = int'($urandom_range(3072)) - 1024;
    endcase
    return RATIO_W'(v);
  endfunction

  function automatic int pick_dim();
    case ($urandom_range(39))
      0:       return 0;                              // empty image
      1, 2:    return $urandom_range(MAX_DIM + 1, 16383); // saturates to MAX_DIM
      3, 4, 5: return $urandom_range(1, 64);
      default: return $urandom_range(1, MAX_DIM);
    endcase
  endfunction

  // Boxes placed in and around the image, some with a non-positive size,
  // and a tenth of pure noise over the whole field range
  function automatic box_t random_box();
    int   kind, iw, ih, span_w, span_h;
    box_t b;
    kind = $urandom_range(99);
    if (kind >= 90) begin
      b       = '0;
      b.x     = $urandom;
      b.y     = $urandom;
      b.w     = $urandom;
      b.h     = $urandom;
      b.img_w = DIM_W'($urandom_range(16383));
      b.img_h = DIM_W'($urandom_range(16383));
      return b;
    end
    iw     = pick_dim();
    ih     = pick_dim();
    span_w = (iw == 0) ? 1 : ((iw > MAX_DIM) ? MAX_DIM : iw);
    span_h = (ih == 0) ? 1 : ((ih > MAX_DIM) ? MAX_DIM : ih);
    b = box_of(int'($urandom_range(span_w + span_w / 4)) - span_w / 8,
               int'($urandom_range(span_h + span_h / 4)) - span_h / 8,
               int'($urandom_range(1, span_w)), int'($urandom_range(1, span_h)),
               iw, ih);
    if (kind >= 80) begin
      if ($urandom_range(1)) b.w = -int'($urandom_range(64));
      else                   b.h = -int'($urandom_range(64));
    end
    return b;
  endfunction

  // Present one request after a random idle stretch and hold it until taken
  task automatic send_box(box_t b);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Hold the request side quiet until every owed crop has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [RATIO_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Write the whole register file while the pipeline is empty, plus one
  // write to an undefined index that must leave everything unchanged
  task automatic load_setting(logic [RATIO_W-1:0] l, logic [RATIO_W-1:0] r,
                              logic [RATIO_W-1:0] t, logic [RATIO_W-1:0] b,
                              logic en, logic [1:0] mode);
    drain();
    cfg_write(CFG_LEFT_RATIO, l);
    cfg_write(CFG_RIGHT_RATIO, r);
    cfg_write(CFG_SPARE | CFG_IDX_W'($urandom_range(1)), RATIO_W'($urandom));
    cfg_write(CFG_TOP_RATIO, t);
    cfg_write(CFG_BOTTOM_RATIO, b);
    cfg_write(CFG_SQUARE_ENABLE, RATIO_W'(en));
    cfg_write(CFG_BASE_SELECT, RATIO_W'(mode));
    cfg_valid <= 1'b0;
  endtask

  // Every fifth phase pins all ratios to an extreme; square mode and the
  // base selection rotate with the phase number
  task automatic setup_phase(int p);
    logic [RATIO_W-1:0] rt [NUM_EDGES];
    foreach (rt[i]) rt[i] = pick_ratio();
    if (p % 5 == 4) begin
      foreach (rt[i]) begin
        if (p == 9)       rt[i] = 16'h8000;
        else if (p == 14) rt[i] = (i % 2) ? 16'h8000 : 16'h7FFF;
        else              rt[i] = 16'h7FFF;
      end
    end
    load_setting(rt[EDGE_LEFT], rt[EDGE_RIGHT], rt[EDGE_TOP], rt[EDGE_BOTTOM],
                 logic'(p % 2), 2'((p / 2) % 4));
  endtask

  initial begin
    tx_idle_pct = 31;
    rx_idle_pct = 66;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed boxes against the reset registers: plain mode, zero ratios
    send_box(box_of(10, 20, 30, 40, 640, 480));
    send_box(box_of(10, 20, 0, 40, 640, 480));               // zero width
    send_box(box_of(10, 20, 30, -5, 640, 480));              // negative height
    send_box(box_of(0, 0, COORD_MIN, COORD_MIN, 640, 480));
    send_box(box_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, MAX_DIM, MAX_DIM));
    send_box(box_of(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, MAX_DIM, MAX_DIM));
    send_box(box_of(0, 0, 10, 10, 0, 0));                    // zero image, empty crop
    send_box(box_of(0, 0, 10000, 10000, 16383, 16383));      // image saturates
    send_box(box_of(0, 0, 1, 1, 1, 1));
    send_box(box_of(700, 10, 30, 30, 640, 480));             // off the right edge
    send_box(box_of(-5, -5, 10, 10, 640, 480));              // clipped at the origin

    // Square around the centre on the shorter side
    load_setting('0, '0, '0, '0, 1'b1, BASE_MIN);
    send_box(box_of(100, 100, 40, 10, 640, 480));
    send_box(box_of(100, 100, 10, 40, 640, 480));

    // Unused base code behaves as the mean, with the largest ratios
    load_setting(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, BASE_SPARE);
    send_box(box_of(100, 100, 40, 10, 640, 480));
    send_box(box_of(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, MAX_DIM, MAX_DIM));

    // Plain mode with opposite extremes on the two sides
    load_setting(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b0, BASE_MEAN);
    send_box(box_of(100, 100, 40, 10, 640, 480));
    send_box(box_of(4000, 3000, 50, 60, MAX_DIM, MAX_DIM));

    // Random phases: sender idles 31% and receiver 66%, then swapped, then
    // back to back on both sides
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES / 3) begin
        tx_idle_pct = 66;
        rx_idle_pct = 31;
      end else if (p == 2 * NUM_PHASES / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      setup_phase(p);
      repeat (BOXES_PER_PHASE) send_box(random_box());
    end

    // Wait out the owed crops, then watch a little longer for strays
    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("roi_box_expand_clamp_tb: PASS");
    end else begin
      $display("roi_box_expand_clamp_tb: FAIL");
    end
    $finish;
  end

  // Hard stop, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("roi_box_expand_clamp_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
